// ----- rtl/mlpf_pkg.sv -----
// mlpf_pkg: shared constants for the multilevel priority fifo
// default sizes and action codes; no dependencies
package mlpf_pkg;

    localparam int LEVELS_DEF       = 16;
    localparam int LEVEL_DEPTH_DEF  = 16;
    localparam int HANDLE_WIDTH_DEF = 16;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

endpackage

// ----- rtl/multilevel_priority_fifo.sv -----
// multilevel_priority_fifo: priority queue of LEVELS levels, one fifo of handles per level
// depends on mlpf_pkg for default sizes and action codes
//
//  channel   handshake              beat fields
//  command   start, busy            action, priority_req, item_handle
//  result    done (one-cycle)       handle_out, handle_valid, dropped, top_level, total_count
//
// one command per cycle; busy stays low, so start may be high in every cycle
// result strobe done comes from the result register, which is loaded from the input register
// (input register, then state update with the store read registered alongside the result)
// the per-level fill, head and nonempty mask clear at reset; the handle store is not cleared
// results cannot be stalled: each one shows on the result ports for exactly one cycle
module multilevel_priority_fifo
    import mlpf_pkg::*;
#(
    parameter int LEVELS       = LEVELS_DEF,
    parameter int LEVEL_DEPTH  = LEVEL_DEPTH_DEF,
    parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    output logic                                        busy,
    input  logic                                        action,
    input  logic [$clog2(LEVELS)-1:0]                   priority_req,
    input  logic [HANDLE_WIDTH-1:0]                     item_handle,
    output logic                                        done,
    output logic [HANDLE_WIDTH-1:0]                     handle_out,
    output logic                                        handle_valid,
    output logic                                        dropped,
    output logic [$clog2(LEVELS+1)-1:0]                 top_level,
    output logic [$clog2(LEVELS*LEVEL_DEPTH+1)-1:0]     total_count
);

    localparam int LVW = $clog2(LEVELS);
    localparam int TLW = $clog2(LEVELS + 1);
    localparam int SLW = $clog2(LEVEL_DEPTH);
    localparam int FW  = $clog2(LEVEL_DEPTH + 1);
    localparam int CW  = $clog2(LEVELS * LEVEL_DEPTH + 1);
    localparam int AW  = LVW + SLW;

    typedef logic [SLW-1:0] slot_t;
    typedef logic [FW-1:0]  fill_t;

    // input register
    logic                    in_valid_reg;
    logic                    in_action_reg;
    logic [LVW-1:0]          in_prio_reg;
    logic [HANDLE_WIDTH-1:0] in_handle_reg;

    // per-level state
    slot_t                   head_reg [LEVELS];
    fill_t                   fill_reg [LEVELS];
    logic [LEVELS-1:0]       mask_reg;
    logic [LEVELS-1:0]       mask_next;
    logic [CW-1:0]           held_reg;
    logic [CW-1:0]           held_next;

    // handle store
    logic [HANDLE_WIDTH-1:0] store_mem [2**AW];
    logic [HANDLE_WIDTH-1:0] rd_data_reg;

    // result register
    logic                    res_valid_reg;
    logic                    res_hvalid_reg;
    logic                    res_drop_reg;
    logic [TLW-1:0]          res_top_reg;

    logic                    lv_ok;
    fill_t                   enq_fill;
    slot_t                   enq_head;
    logic [SLW:0]            slot_sum;
    slot_t                   enq_slot;
    logic                    is_enq;
    logic                    enq_ok;
    logic                    deq_ok;
    logic [TLW-1:0]          best_before;
    logic [TLW-1:0]          best_after;
    logic [LVW-1:0]          deq_lv;
    slot_t                   deq_head;
    fill_t                   deq_fill;
    slot_t                   deq_head_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_action_reg <= action;
            in_prio_reg   <= priority_req;
            in_handle_reg <= item_handle;
        end
    end

    // lowest set bit of the nonempty mask before the step
    always_comb
    begin
        best_before = TLW'(LEVELS);
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                best_before = TLW'(i);
            end
        end
    end

    always_comb
    begin
        lv_ok    = {1'b0, in_prio_reg} < (LVW+1)'(LEVELS);
        enq_fill = lv_ok ? fill_reg[in_prio_reg] : fill_t'(LEVEL_DEPTH);
        enq_head = lv_ok ? head_reg[in_prio_reg] : '0;
        is_enq   = in_valid_reg && (in_action_reg == ACT_ENQ);
        enq_ok   = is_enq && lv_ok && (enq_fill < fill_t'(LEVEL_DEPTH));

        slot_sum = (SLW+1)'(enq_head) + (SLW+1)'(enq_fill);
        if (slot_sum >= (SLW+1)'(LEVEL_DEPTH))
        begin
            slot_sum = slot_sum - (SLW+1)'(LEVEL_DEPTH);
        end
        enq_slot = slot_sum[SLW-1:0];

        deq_lv   = best_before[LVW-1:0];
        deq_ok   = in_valid_reg && (in_action_reg == ACT_DEQ) && (mask_reg != '0);
        deq_head = head_reg[deq_lv];
        deq_fill = fill_reg[deq_lv];
        if (deq_head == slot_t'(LEVEL_DEPTH - 1))
        begin
            deq_head_next = '0;
        end
        else
        begin
            deq_head_next = deq_head + slot_t'(1);
        end

        mask_next = mask_reg;
        held_next = held_reg;
        if (enq_ok)
        begin
            mask_next[in_prio_reg] = 1'b1;
            held_next              = held_reg + CW'(1);
        end
        else if (deq_ok)
        begin
            if (deq_fill == fill_t'(1))
            begin
                mask_next[deq_lv] = 1'b0;
            end
            held_next = held_reg - CW'(1);
        end
    end

    // lowest set bit of the nonempty mask after the step
    always_comb
    begin
        best_after = TLW'(LEVELS);
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (mask_next[i])
            begin
                best_after = TLW'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
            mask_reg       <= '0;
            held_reg       <= '0;
            res_valid_reg  <= 1'b0;
            res_hvalid_reg <= 1'b0;
            res_drop_reg   <= 1'b0;
            res_top_reg    <= TLW'(LEVELS);
        end
        else
        begin
            if (enq_ok)
            begin
                fill_reg[in_prio_reg] <= enq_fill + fill_t'(1);
            end
            else if (deq_ok)
            begin
                fill_reg[deq_lv] <= deq_fill - fill_t'(1);
                head_reg[deq_lv] <= deq_head_next;
            end
            mask_reg       <= mask_next;
            held_reg       <= held_next;
            res_valid_reg  <= in_valid_reg;
            res_hvalid_reg <= deq_ok;
            res_drop_reg   <= is_enq && !enq_ok;
            res_top_reg    <= best_after;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq_ok)
        begin
            store_mem[{in_prio_reg, enq_slot}] <= in_handle_reg;
        end
        rd_data_reg <= store_mem[{deq_lv, deq_head}];
    end

    assign done         = res_valid_reg;
    assign handle_valid = res_hvalid_reg;
    assign handle_out   = res_hvalid_reg ? rd_data_reg : '0;
    assign dropped      = res_drop_reg;
    assign top_level    = res_top_reg;
    assign total_count  = held_reg;

    // every accepted beat gives exactly one result, registered from the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |=> done)
        else $error("accepted beat produced no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(handle_valid && dropped))
        else $error("result both returned and dropped a handle");

    // count and mask must agree on emptiness
    assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg == '0) == (mask_reg == '0))
        else $error("total count disagrees with nonempty mask");

    assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CW'(LEVELS * LEVEL_DEPTH))
        else $error("total count above capacity");

endmodule
